// ===== design/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and codes for the page lifecycle table.
// ----------------------------------------------------------------------------
package plt_pkg;

  typedef enum logic [3:0] {
    OP_RESERVE    = 4'd0,
    OP_BEGIN_COPY = 4'd1,
    OP_CANCEL     = 4'd2,
    OP_COMPLETE   = 4'd3,
    OP_QUARANTINE = 4'd4,
    OP_RECLAIM    = 4'd5,
    OP_ACQUIRE    = 4'd6,
    OP_RELEASE    = 4'd7,
    OP_EVICT      = 4'd8,
    OP_RETIRE     = 4'd9,
    OP_MATCH      = 4'd10,
    OP_QUERY      = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    PH_RESERVED    = 2'd0,
    PH_COPYING     = 2'd1,
    PH_READY       = 2'd2,
    PH_QUARANTINED = 2'd3
  } phase_t;

  localparam logic [1:0] ST_SUCCESS = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  localparam logic [15:0] READERS_MAX = 16'hFFFF;

  // request as it travels along the row of cells
  typedef struct packed {
    logic [3:0]  op;
    logic        copy_valid;
    logic        lease_free;
    logic [63:0] print;
    logic        claim;      // a free cell has taken the reserve
    logic        found;      // a cell holds the ticket
    logic        ok;
    logic        fatal;
    logic [1:0]  phase;
    logic [31:0] size;
    logic [31:0] freed;      // bytes handed back by a removal
  } req_t;

endpackage

// ===== design/page_lifecycle_table.sv =====
// ----------------------------------------------------------------------------
// page_lifecycle_table
// Page slot table with ticketed lifecycle requests.
// ----------------------------------------------------------------------------
// One request at a time. A request is taken, then walks the row of
// PAGE_SLOTS cells one cell per cycle (the cell chain sets the figure), and its
// result is registered and held while out_stall is high. A reserve is checked
// against the slot count, budget and ticket space on entry; the first free
// cell on the walk claims it.
module page_lifecycle_table #(
  parameter int PAGE_SLOTS  = 32,
  parameter int TICKET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_opcode,
  input  logic [31:0] in_ticket,
  input  logic [31:0] in_request_bytes,
  input  logic        in_layout_ok,
  input  logic [63:0] in_schema_print,
  input  logic        in_copy_valid,
  input  logic        in_lease_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [1:0]  out_status,
  output logic [31:0] out_new_ticket,
  output logic [1:0]  out_page_phase,
  output logic [31:0] out_page_bytes,
  output logic        out_fatal,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int CW = $clog2(PAGE_SLOTS + 1);
  localparam int TW = (TICKET_BITS < 32) ? TICKET_BITS : 32;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_WALK = 3'b010, S_DONE = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [31:0]            budget_r;
  logic [5:0]             limit_r;
  logic [TICKET_BITS-1:0] next_id_r, tkt_r;
  logic [31:0]            in_use_r, bytes_r;
  logic [IW-1:0]          pos_r;
  logic                   resv_r;
  logic [1:0]             status_r;
  plt_pkg::req_t          cur_r, cell_out, walk_nxt;
  plt_pkg::req_t          chain [PAGE_SLOTS];
  logic [PAGE_SLOTS-1:0]  used_v;
  logic [CW-1:0]          count;
  logic [31:0]            room;
  logic [CW:0]            lim;
  logic                   accept, last;

  // slot count: a popcount of the used flags
  always_comb begin
    count = '0;
    for (int i = 0; i < PAGE_SLOTS; i++) count = count + CW'(used_v[i]);
  end

  assign room = (in_use_r < budget_r) ? budget_r - in_use_r : 32'd0;
  assign lim  = ((CW+1)'(limit_r) < (CW+1)'(PAGE_SLOTS)) ? (CW+1)'(limit_r)
                                                         : (CW+1)'(PAGE_SLOTS);
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign last      = (pos_r == IW'(PAGE_SLOTS - 1));

  // row of cells; only the addressed one steps in a given cycle
  for (genvar g = 0; g < PAGE_SLOTS; g++) begin : g_cell
    plt_cell #(.TICKET_BITS(TICKET_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .step(state_r == S_WALK && pos_r == IW'(g)),
      .do_reserve(resv_r), .ticket(tkt_r), .issue_id(next_id_r),
      .req_bytes(bytes_r), .req_in(cur_r), .req_out(chain[g]),
      .used(used_v[g])
    );
  end
  assign cell_out = chain[pos_r];

  // request handed on to the next cell, freed bytes already counted
  always_comb begin
    walk_nxt       = cell_out;
    walk_nxt.freed = 32'd0;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_WALK;
      S_WALK:  if (last) state_nxt = S_DONE;
      S_DONE:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      budget_r  <= '0;
      limit_r   <= 6'd32;
      next_id_r <= '0;
      in_use_r  <= '0;
      pos_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == plt_pkg::CFG_BUDGET) budget_r <= cfg_data;
        else limit_r <= cfg_data[5:0];
      end
      if (accept) pos_r <= '0;
      else if (state_r == S_WALK && !last) pos_r <= pos_r + IW'(1);
      if (state_r == S_WALK) begin
        in_use_r <= in_use_r - cell_out.freed +
                    ((last && cell_out.claim) ? bytes_r : 32'd0);
        if (last && cell_out.claim) next_id_r <= next_id_r + TICKET_BITS'(1);
      end
    end
  end

  // request register; freed bytes apply once per cell
  always_ff @(posedge clk) begin
    if (accept) begin
      tkt_r   <= TICKET_BITS'(in_ticket);
      bytes_r <= in_request_bytes;
      cur_r   <= '{op: in_opcode, copy_valid: in_copy_valid,
                   lease_free: in_lease_free, print: in_schema_print,
                   claim: 1'b0, found: 1'b0, ok: 1'b0, fatal: 1'b0,
                   phase: 2'd0, size: 32'd0, freed: 32'd0};
      resv_r   <= 1'b0;
      status_r <= plt_pkg::ST_SUCCESS;
      if (plt_pkg::op_t'(in_opcode) == plt_pkg::OP_RESERVE) begin
        if (!in_layout_ok || in_request_bytes == 32'd0)
          status_r <= plt_pkg::ST_INVALID;
        else if ((CW+1)'(count) >= lim || in_request_bytes > room || &next_id_r)
          status_r <= plt_pkg::ST_FULL;
        else
          resv_r <= 1'b1;
      end
    end else if (state_r == S_WALK) begin
      cur_r <= walk_nxt;
    end
  end

  // result fields
  assign out_valid      = (state_r == S_DONE);
  assign out_status     = status_r;
  assign out_ok         = (cur_r.op == 4'(plt_pkg::OP_RESERVE)) ? cur_r.claim : cur_r.ok;
  assign out_new_ticket = (cur_r.op == 4'(plt_pkg::OP_RESERVE) && cur_r.claim)
                          ? 32'(next_id_r[TW-1:0] - TW'(1)) : 32'd0;
  assign out_page_phase = cur_r.phase;
  assign out_page_bytes = cur_r.size;
  assign out_fatal      = (cur_r.op == 4'(plt_pkg::OP_RELEASE)) &&
                          (cur_r.fatal || !cur_r.found);

endmodule

// ===== design/plt_cell.sv =====
// ----------------------------------------------------------------------------
// plt_cell
// One page slot: matches the travelling request and updates its own entry.
// ----------------------------------------------------------------------------
module plt_cell #(
  parameter int TICKET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,        // request sits at this cell
  input  logic                   do_reserve,  // reserve passed all checks
  input  logic [TICKET_BITS-1:0] ticket,
  input  logic [TICKET_BITS-1:0] issue_id,
  input  logic [31:0]            req_bytes,
  input  plt_pkg::req_t          req_in,
  output plt_pkg::req_t          req_out,
  output logic                   used
);

  logic                   used_r, used_nxt;
  logic [TICKET_BITS-1:0] tkt_r;
  logic [1:0]             ph_r, ph_nxt;
  logic [15:0]            rd_r, rd_nxt;
  logic                   can_r, can_nxt, ret_r, ret_nxt;
  logic [31:0]            size_r;
  logic [63:0]            prn_r;
  logic                   hit, take, drop;

  assign used = used_r;
  assign hit  = used_r && (tkt_r == ticket);
  assign take = (plt_pkg::op_t'(req_in.op) == plt_pkg::OP_RESERVE) && do_reserve
                && !used_r && !req_in.claim;

  // lifecycle rules for this slot
  always_comb begin
    req_out  = req_in;
    used_nxt = used_r;
    ph_nxt   = ph_r;
    rd_nxt   = rd_r;
    can_nxt  = can_r;
    ret_nxt  = ret_r;
    drop     = 1'b0;
    if (take) begin
      req_out.claim = 1'b1;
      used_nxt = 1'b1;
      ph_nxt   = plt_pkg::PH_RESERVED;
      rd_nxt   = '0;
      can_nxt  = 1'b0;
      ret_nxt  = 1'b0;
    end else if (hit) begin
      req_out.found = 1'b1;
      case (plt_pkg::op_t'(req_in.op))
        plt_pkg::OP_BEGIN_COPY: if (ph_r == plt_pkg::PH_RESERVED) begin
          ph_nxt = plt_pkg::PH_COPYING; req_out.ok = 1'b1;
        end
        plt_pkg::OP_CANCEL: begin
          if (ph_r == plt_pkg::PH_RESERVED) begin
            drop = 1'b1; req_out.ok = 1'b1;
          end else if (ph_r == plt_pkg::PH_COPYING) begin
            can_nxt = 1'b1; req_out.ok = 1'b1;
          end
        end
        plt_pkg::OP_COMPLETE: if (ph_r == plt_pkg::PH_COPYING) begin
          if (!req_in.copy_valid || can_r) drop = 1'b1;
          else ph_nxt = plt_pkg::PH_READY;
          req_out.ok = 1'b1;
        end
        plt_pkg::OP_QUARANTINE: if (ph_r == plt_pkg::PH_COPYING) begin
          ph_nxt = plt_pkg::PH_QUARANTINED; req_out.ok = 1'b1;
        end
        plt_pkg::OP_RECLAIM: if (ph_r == plt_pkg::PH_QUARANTINED) begin
          drop = 1'b1; req_out.ok = 1'b1;
        end
        plt_pkg::OP_ACQUIRE: if (req_in.lease_free && ph_r == plt_pkg::PH_READY &&
                                 !ret_r && rd_r != plt_pkg::READERS_MAX) begin
          rd_nxt = rd_r + 16'd1; req_out.ok = 1'b1;
        end
        plt_pkg::OP_RELEASE: begin
          if (rd_r == '0) begin
            req_out.fatal = 1'b1;
          end else begin
            rd_nxt = rd_r - 16'd1;
            if (rd_r == 16'd1 && ret_r) drop = 1'b1;
            req_out.ok = 1'b1;
          end
        end
        plt_pkg::OP_EVICT: if (ph_r == plt_pkg::PH_READY && rd_r == '0) begin
          drop = 1'b1; req_out.ok = 1'b1;
        end
        plt_pkg::OP_RETIRE: if (ph_r == plt_pkg::PH_READY) begin
          ret_nxt = 1'b1;
          if (rd_r == '0) drop = 1'b1;
          req_out.ok = 1'b1;
        end
        plt_pkg::OP_MATCH: req_out.ok = (prn_r == req_in.print);
        plt_pkg::OP_QUERY: begin
          req_out.ok = 1'b1; req_out.phase = ph_r; req_out.size = size_r;
        end
        default: ;
      endcase
      if (drop) begin
        used_nxt = 1'b0;
        req_out.freed = size_r;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (step) begin
      used_r <= used_nxt;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (step) begin
      ph_r  <= ph_nxt;
      rd_r  <= rd_nxt;
      can_r <= can_nxt;
      ret_r <= ret_nxt;
      if (take) begin
        tkt_r  <= issue_id;
        size_r <= req_bytes;
        prn_r  <= req_in.print;
      end
    end
  end

endmodule

// ===== design/plt_checker.sv =====
// ----------------------------------------------------------------------------
// plt_checker
// Port-level checks for the page lifecycle table.
// ----------------------------------------------------------------------------
module plt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_ok,
  input logic [1:0]  out_status,
  input logic        out_fatal,
  input logic [31:0] out_new_ticket
);

  // one request in flight: no result while input is open
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result shown while input open");

  // failed reserve never issues a ticket
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != plt_pkg::ST_SUCCESS |-> !out_ok && out_new_ticket == 32'd0)
    else $error("refused reserve with ok");

  // fatal never comes with ok
  a_fatal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fatal |-> !out_ok) else $error("fatal with ok");

  // held result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok))
    else $error("stalled result changed");

endmodule

bind page_lifecycle_table plt_checker u_plt_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_ok(out_ok),
  .out_status(out_status), .out_fatal(out_fatal), .out_new_ticket(out_new_ticket)
);
